// ===== rtl/rie_pkg.sv =====
// shared types and constants of the instruction execute block
`default_nettype none
package rie_pkg;

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RIDX_W = 4;
  localparam int unsigned NREGS  = 16;

  localparam logic [RIDX_W-1:0] LINK_REG = 4'd15;

  localparam logic [3:0] MODE_ADD = 4'd0;
  localparam logic [3:0] MODE_SUB = 4'd1;
  localparam logic [3:0] MODE_AND = 4'd2;
  localparam logic [3:0] MODE_OR  = 4'd3;
  localparam logic [3:0] MODE_SLL = 4'd4;
  localparam logic [3:0] MODE_SRA = 4'd5;
  localparam logic [3:0] MODE_MAC = 4'd6;
  localparam logic [3:0] MODE_BR  = 4'd7;
  localparam logic [3:0] MODE_JAL = 4'd8;
  localparam logic [3:0] MODE_LW  = 4'd9;
  localparam logic [3:0] MODE_SW  = 4'd10;
  localparam logic [3:0] MODE_JR  = 4'd11;

  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_GT = 4'd2;
  localparam logic [3:0] COND_LT = 4'd3;
  localparam logic [3:0] COND_GE = 4'd4;
  localparam logic [3:0] COND_LE = 4'd5;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_MAC,
    OP_BR, OP_JAL, OP_LW, OP_SW, OP_JR, OP_NOP
  } rie_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_RUN, ST_FINISH
  } rie_state_e;

  typedef struct packed {
    rie_op_e           op;
    logic              is_long;
    logic [RIDX_W-1:0] dest;
    logic [RIDX_W-1:0] ra;
    logic [RIDX_W-1:0] rb;
    logic [RIDX_W-1:0] rc;
    logic [DATA_W-1:0] imm;
  } rie_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } rie_back_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] mem_value;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_written;
    logic [DATA_W-1:0] reg_value;
    logic              reg_written;
    logic [ADDR_W-1:0] next_pc;
  } rie_result_t;

endpackage
`default_nettype wire

// ===== rtl/rie_front.sv =====
// front part: accepts items, classifies them and queues them for execution
`default_nettype none
module rie_front
  import rie_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [55:0]    in_data_i,
  input  wire rie_back_stat_t stat_i,
  output logic                q_valid_o,
  output rie_item_t           q_item_o
);

  rie_item_t  slot_q [2];
  logic       rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  rie_item_t  dec;

  always_comb begin
    dec.dest = in_data_i[7:4];
    dec.ra   = in_data_i[11:8];
    dec.rb   = in_data_i[15:12];
    dec.rc   = in_data_i[19:16];
    dec.imm  = in_data_i[51:20];
    case (in_data_i[3:0])
      MODE_ADD: dec.op = OP_ADD;
      MODE_SUB: dec.op = OP_SUB;
      MODE_AND: dec.op = OP_AND;
      MODE_OR:  dec.op = OP_OR;
      MODE_SLL: dec.op = OP_SLL;
      MODE_SRA: dec.op = OP_SRA;
      MODE_MAC: dec.op = OP_MAC;
      MODE_BR:  dec.op = OP_BR;
      MODE_JAL: dec.op = OP_JAL;
      MODE_LW:  dec.op = OP_LW;
      MODE_SW:  dec.op = OP_SW;
      MODE_JR:  dec.op = OP_JR;
      default:  dec.op = OP_NOP;
    endcase
    dec.is_long = (dec.op == OP_MAC) || (dec.op == OP_LW);
  end

  assign in_ready_o = (cnt_q != 2'd2) && !stat_i.clearing;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ stat_i.pop;
    wr_ptr_d = wr_ptr_q ^ push;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, stat_i.pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rie_back.sv =====
// back part: register file, data memory, pc and result register
`default_nettype none
module rie_back
  import rie_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire rie_item_t q_item_i,
  output rie_back_stat_t stat_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rie_result_t    out_o
);

  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  rie_state_e        state_q, state_d;
  logic [DATA_W-1:0] regs_q [NREGS];
  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [AW-1:0]     clr_q, clr_d;
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic              out_valid_q, out_valid_d;
  rie_result_t       out_q;

  logic [DATA_W-1:0] prod_q, addend_q, rdata_q;
  logic              oob_q;
  logic [RIDX_W-1:0] hdest_q;
  logic              hlw_q;
  logic [ADDR_W-1:0] haddr_q, hpc_q;

  logic              can_out, fire_short, issue_long, fire_finish, clearing;
  logic [DATA_W-1:0] a, b, c, d;
  logic [ADDR_W-1:0] pc_inc, maddr;
  logic              in_range, taken, hold_pc;
  logic [4:0]        sh;
  rie_result_t       res;
  logic [DATA_W-1:0] fval;
  rie_result_t       fin;
  logic [RIDX_W-1:0] wdest;
  logic              wr_en;
  logic [DATA_W-1:0] wval;

  assign can_out = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == AW'(MEM_DEPTH - 1)) state_d = ST_RUN;
      ST_RUN:    if (q_valid_i && q_item_i.is_long) state_d = ST_FINISH;
      ST_FINISH: if (can_out) state_d = ST_RUN;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    clearing    = 1'b0;
    fire_short  = 1'b0;
    issue_long  = 1'b0;
    fire_finish = 1'b0;
    case (state_q)
      ST_CLEAR:  clearing = 1'b1;
      ST_RUN: begin
        fire_short = q_valid_i && !q_item_i.is_long && can_out;
        issue_long = q_valid_i && q_item_i.is_long;
      end
      ST_FINISH: fire_finish = can_out;
      default:   clearing = 1'b0;
    endcase
  end

  assign stat_o.pop      = fire_short || issue_long;
  assign stat_o.clearing = clearing;
  assign clr_d           = clr_q + AW'(1);

  always_comb begin
    a        = regs_q[q_item_i.ra];
    b        = regs_q[q_item_i.rb];
    c        = regs_q[q_item_i.rc];
    d        = regs_q[q_item_i.dest];
    pc_inc   = pc_q + ADDR_W'(1);
    maddr    = a[ADDR_W-1:0] + q_item_i.imm[ADDR_W-1:0];
    in_range = {1'b0, maddr} < (ADDR_W + 1)'(MEM_DEPTH);
    sh       = b[4:0] + q_item_i.imm[4:0];
    taken    = 1'b0;
    hold_pc  = 1'b0;
    case (q_item_i.rc)
      COND_EQ: taken = $signed(a) == $signed(b);
      COND_NE: taken = $signed(a) != $signed(b);
      COND_GT: taken = $signed(a) >  $signed(b);
      COND_LT: taken = $signed(a) <  $signed(b);
      COND_GE: taken = $signed(a) >= $signed(b);
      COND_LE: taken = $signed(a) <= $signed(b);
      default: hold_pc = 1'b1;
    endcase
    res             = '0;
    res.next_pc     = pc_inc;
    res.reg_written = 1'b1;
    case (q_item_i.op)
      OP_ADD: res.reg_value = a + b + q_item_i.imm;
      OP_SUB: res.reg_value = a - b - q_item_i.imm;
      OP_AND: res.reg_value = a & b & q_item_i.imm;
      OP_OR:  res.reg_value = a | b | q_item_i.imm;
      OP_SLL: res.reg_value = a << sh;
      OP_SRA: res.reg_value = $unsigned($signed(a) >>> sh);
      OP_BR: begin
        res.reg_written = 1'b0;
        if (taken)        res.next_pc = q_item_i.imm[ADDR_W-1:0];
        else if (hold_pc) res.next_pc = pc_q;
      end
      OP_JAL: begin
        res.reg_value = DATA_W'(pc_inc);
        res.next_pc   = q_item_i.imm[ADDR_W-1:0];
      end
      OP_SW: begin
        res.reg_written = 1'b0;
        res.mem_written = in_range;
        res.mem_addr    = maddr;
        res.mem_value   = d;
      end
      OP_JR: begin
        res.reg_written = 1'b0;
        res.next_pc     = d[ADDR_W-1:0];
      end
      default: res.reg_written = 1'b0;
    endcase
  end

  // result of a long item, from the values registered when it was issued
  always_comb begin
    fval            = hlw_q ? (oob_q ? '0 : rdata_q) : (prod_q + addend_q);
    fin             = '0;
    fin.next_pc     = hpc_q;
    fin.reg_written = 1'b1;
    fin.reg_value   = fval;
    if (hlw_q) begin
      fin.mem_addr  = haddr_q;
      fin.mem_value = fval;
    end
  end

  // register file write: short items when they fire, long ones when they finish
  always_comb begin
    wr_en = 1'b0;
    wdest = q_item_i.dest;
    wval  = res.reg_value;
    if (fire_short) begin
      wr_en = res.reg_written;
      if (q_item_i.op == OP_JAL) wdest = LINK_REG;
    end else if (fire_finish) begin
      wr_en = 1'b1;
      wdest = hdest_q;
      wval  = fval;
    end
  end

  always_comb begin
    pc_d = pc_q;
    if (fire_short)      pc_d = res.next_pc;
    else if (issue_long) pc_d = pc_inc;
    out_valid_d = (out_valid_q && !out_ready_i) || fire_short || fire_finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NREGS; i++) regs_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (clearing) clr_q <= clr_d;
      if (wr_en) regs_q[wdest] <= wval;
    end
  end

  // data memory, one port used by the clearing pass, sw and lw
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_q] <= '0;
    end else if (fire_short && res.mem_written) begin
      mem[maddr[AW-1:0]] <= d;
    end
    if (issue_long) begin
      rdata_q <= mem[maddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_long) begin
      prod_q   <= a * b;
      addend_q <= c + q_item_i.imm;
      oob_q    <= !in_range;
      hdest_q  <= q_item_i.dest;
      hlw_q    <= (q_item_i.op == OP_LW);
      haddr_q  <= maddr;
      hpc_q    <= pc_inc;
    end
    if (fire_short) begin
      out_q <= res;
    end else if (fire_finish) begin
      out_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ===== rtl/risc_instruction_execute_top.sv =====
// top level of the instruction execute block
`default_nettype none
// Executes one decoded instruction per item against sixteen 32-bit registers,
// a MEM_DEPTH-word data memory and a 12-bit pc, giving one result item per
// input item. Most instructions finish in the execute stage as they are
// issued; mac and lw finish in a later state (the multiplier output and the
// synchronous memory read are registered before writeback), and the next item
// waits behind them because it may read what they write. A two-entry queue
// separates the decoder from the execute stage and an output register
// separates it from the consumer. After reset the data memory is zeroed by a
// clearing pass over all MEM_DEPTH words, during which no item is accepted.
module risc_instruction_execute_top
  import rie_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // mode[3:0] dest_reg[7:4] src_reg_a[11:8] src_reg_b[15:12]
  // src_reg_c[19:16] immediate[51:20], zero pad [55:52]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // next_pc[11:0] reg_written[12] reg_value[44:13] mem_written[45]
  // mem_addr[57:46] mem_value[89:58], zero pad [95:90]
  output logic [95:0]      m_axis_tdata_o
);

  logic           q_valid;
  rie_item_t      q_item;
  rie_back_stat_t stat;
  rie_result_t    res;

  // decode and queue
  rie_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .stat_i     (stat),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item)
  );

  // execute, state and result register
  rie_back #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {6'd0, res};

`ifndef NO_ASSERTIONS
  // no item enters while the memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready_o) else $error("item accepted during clear");
  // the queue is never popped while the back end is clearing
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !stat.pop) else $error("queue popped during clear");
  // a store never also writes a register
  a_store_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.mem_written) |-> !res.reg_written)
    else $error("store reported a register write");
`endif

endmodule
`default_nettype wire

// ===== sim/risc_instruction_execute_top_test.sv =====
// testbench of the instruction execute block: directed table then random programs
`timescale 1ns / 100ps
`default_nettype none
module risc_instruction_execute_top_test;
  import rie_pkg::*;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned WDOG_MAX  = 40000;
  localparam int unsigned N_RANDOM  = 1250;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // mode, dest_reg, src_reg_a, src_reg_b, src_reg_c, immediate, zero pad
  logic [55:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // next_pc, reg_written, reg_value, mem_written, mem_addr, mem_value, zero pad
  logic [95:0] m_axis_tdata_o;

  risc_instruction_execute_top #(.MEM_DEPTH(DEPTH)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #2 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] imm;
    logic [3:0]  rc;
    logic [3:0]  rb;
    logic [3:0]  ra;
    logic [3:0]  rd;
    logic [3:0]  mode;
  } instr_t;

  // predictor state, a shadow of the block
  logic [31:0] shadow_regs [16];
  logic [31:0] shadow_mem [DEPTH];
  logic [11:0] shadow_pc;

  rie_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned wdog = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // execute one instruction on the shadow state, giving its result
  function automatic rie_result_t execute_instr(input instr_t ins);
    rie_result_t r;
    logic [31:0] a, b, c, v;
    logic [11:0] inc;
    logic [4:0]  sh;
    logic [63:0] prod;
    logic [3:0]  wr_idx;
    logic        taken;
    a = shadow_regs[ins.ra];
    b = shadow_regs[ins.rb];
    c = shadow_regs[ins.rc];
    inc = shadow_pc + 12'd1;
    sh = 5'(b + ins.imm);
    r = '0;
    r.next_pc = inc;
    wr_idx = ins.rd;
    case (ins.mode)
      MODE_ADD: begin r.reg_written = 1'b1; r.reg_value = a + b + ins.imm; end
      MODE_SUB: begin r.reg_written = 1'b1; r.reg_value = a - b - ins.imm; end
      MODE_AND: begin r.reg_written = 1'b1; r.reg_value = a & b & ins.imm; end
      MODE_OR:  begin r.reg_written = 1'b1; r.reg_value = a | b | ins.imm; end
      MODE_SLL: begin r.reg_written = 1'b1; r.reg_value = a << sh; end
      MODE_SRA: begin r.reg_written = 1'b1; r.reg_value = $signed(a) >>> sh; end
      MODE_MAC: begin
        prod = a * b;
        r.reg_written = 1'b1;
        r.reg_value = prod[31:0] + c + ins.imm;
      end
      MODE_BR: begin
        case (ins.rc)
          COND_EQ: taken = $signed(a) == $signed(b);
          COND_NE: taken = $signed(a) != $signed(b);
          COND_GT: taken = $signed(a) >  $signed(b);
          COND_LT: taken = $signed(a) <  $signed(b);
          COND_GE: taken = $signed(a) >= $signed(b);
          COND_LE: taken = $signed(a) <= $signed(b);
          default: begin taken = 1'b0; inc = shadow_pc; end
        endcase
        r.next_pc = taken ? ins.imm[11:0] : inc;
      end
      MODE_JAL: begin
        r.reg_written = 1'b1;
        r.reg_value = 32'(inc);
        wr_idx = LINK_REG;
        r.next_pc = ins.imm[11:0];
      end
      MODE_LW: begin
        v = a + ins.imm;
        r.mem_addr = v[11:0];
        r.mem_value = (r.mem_addr < DEPTH) ? shadow_mem[r.mem_addr] : '0;
        r.reg_written = 1'b1;
        r.reg_value = r.mem_value;
      end
      MODE_SW: begin
        v = a + ins.imm;
        r.mem_addr = v[11:0];
        r.mem_value = shadow_regs[ins.rd];
        if (r.mem_addr < DEPTH) begin
          shadow_mem[r.mem_addr] = r.mem_value;
          r.mem_written = 1'b1;
        end
      end
      MODE_JR: r.next_pc = shadow_regs[ins.rd][11:0];
      default: ;
    endcase
    if (r.reg_written) shadow_regs[wr_idx] = r.reg_value;
    shadow_pc = r.next_pc;
    return r;
  endfunction

  // hand one item to the block, holding it until accepted
  task automatic send_instr(input instr_t ins);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'h0, ins};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(execute_instr(ins));
  endtask

  // random instruction, mostly small addresses so loads meet earlier stores
  function automatic instr_t rand_instr();
    instr_t ins;
    ins.mode = 4'($urandom_range(15));
    if ($urandom_range(9) < 8) ins.mode = 4'($urandom_range(11));
    ins.rd = 4'($urandom);
    ins.ra = 4'($urandom);
    ins.rb = 4'($urandom);
    ins.rc = (ins.mode == MODE_BR && $urandom_range(9) < 8) ?
             4'($urandom_range(5)) : 4'($urandom);
    case ($urandom_range(3))
      0: ins.imm = $urandom;
      1: ins.imm = 32'($urandom_range(31)) - 32'd16;
      2: ins.imm = {{20{1'b0}}, 12'($urandom_range(63))};
      default: ins.imm = {$urandom_range(1) ? 20'hfffff : 20'h0, 12'($urandom)};
    endcase
    return ins;
  endfunction

  // receiver side: random stalls and the field by field check
  always @(posedge clk_i) begin
    rie_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[89:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata_o[31:0], 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.next_pc != want.next_pc)
            report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
          if (got.reg_written != want.reg_written)
            report_mismatch("reg_written", 32'(got.reg_written), 32'(want.reg_written));
          if (got.reg_value != want.reg_value)
            report_mismatch("reg_value", got.reg_value, want.reg_value);
          if (got.mem_written != want.mem_written)
            report_mismatch("mem_written", 32'(got.mem_written), 32'(want.mem_written));
          if (got.mem_addr != want.mem_addr)
            report_mismatch("mem_addr", 32'(got.mem_addr), 32'(want.mem_addr));
          if (got.mem_value != want.mem_value)
            report_mismatch("mem_value", got.mem_value, want.mem_value);
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item; long enough for the clearing pass
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  // directed rows; a typed expectation only where it is plain
  typedef struct {
    instr_t      ins;
    logic        known;
    rie_result_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic instr_t mk(input logic [3:0] mode, input logic [3:0] rd,
                                input logic [3:0] ra, input logic [3:0] rb,
                                input logic [3:0] rc, input logic [31:0] imm);
    return '{imm: imm, rc: rc, rb: rb, ra: ra, rd: rd, mode: mode};
  endfunction

  initial begin
    rie_result_t r;
    for (int i = 0; i < 16; i++) shadow_regs[i] = '0;
    for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;
    shadow_pc = '0;
    // first item after reset: all zero registers, add of max immediate
    r = '0; r.next_pc = 12'd1; r.reg_written = 1'b1; r.reg_value = 32'h7fffffff;
    dir_rows.push_back('{mk(MODE_ADD, 4'd0, 4'd1, 4'd2, 4'd0, 32'h7fffffff), 1'b1, r});
    // load from a never written address reads zero
    r = '0; r.next_pc = 12'd2; r.reg_written = 1'b1; r.mem_addr = 12'hfff;
    dir_rows.push_back('{mk(MODE_LW, 4'd3, 4'd4, 4'd0, 4'd0, 32'hffffffff), 1'b1, r});
    // branch with a bad condition keeps the pc
    r = '0; r.next_pc = 12'd2;
    dir_rows.push_back('{mk(MODE_BR, 4'd0, 4'd0, 4'd0, 4'd9, 32'h123), 1'b1, r});
    // the rest from the predictor
    dir_rows.push_back('{mk(MODE_SUB, 4'd1, 4'd0, 4'd0, 4'd0, 32'h80000000), 1'b0, r});
    dir_rows.push_back('{mk(MODE_AND, 4'd2, 4'd0, 4'd1, 4'd0, 32'hffffffff), 1'b0, r});
    dir_rows.push_back('{mk(MODE_OR, 4'd5, 4'd1, 4'd2, 4'd0, 32'h0f0f0f0f), 1'b0, r});
    dir_rows.push_back('{mk(MODE_SLL, 4'd6, 4'd1, 4'd0, 4'd0, 32'd31), 1'b0, r});
    dir_rows.push_back('{mk(MODE_SRA, 4'd7, 4'd6, 4'd0, 4'd0, 32'd35), 1'b0, r});
    dir_rows.push_back('{mk(MODE_MAC, 4'd8, 4'd0, 4'd1, 4'd5, 32'h80000001), 1'b0, r});
    dir_rows.push_back('{mk(MODE_SW, 4'd8, 4'd0, 4'd0, 4'd0, 32'h00000ffe), 1'b0, r});
    dir_rows.push_back('{mk(MODE_LW, 4'd9, 4'd0, 4'd0, 4'd0, 32'hfffffffe), 1'b0, r});
    dir_rows.push_back('{mk(MODE_SW, 4'd15, 4'd3, 4'd0, 4'd0, 32'd0), 1'b0, r});
    for (int c = 0; c < 6; c++)
      dir_rows.push_back('{mk(MODE_BR, 4'd0, 4'd0, 4'd1, 4'(c), 32'hfffff800 + c), 1'b0, r});
    dir_rows.push_back('{mk(MODE_BR, 4'd0, 4'd2, 4'd2, 4'd15, 32'd5), 1'b0, r});
    // jal to the top of the pc range, then a step that wraps it to zero
    dir_rows.push_back('{mk(MODE_JAL, 4'd3, 4'd0, 4'd0, 4'd0, 32'hffffffff), 1'b0, r});
    dir_rows.push_back('{mk(MODE_ADD, 4'd0, 4'd0, 4'd0, 4'd0, 32'd0), 1'b0, r});
    dir_rows.push_back('{mk(MODE_JR, 4'd15, 4'd0, 4'd0, 4'd0, 32'd0), 1'b0, r});
    dir_rows.push_back('{mk(4'd12, 4'd1, 4'd1, 4'd1, 4'd1, 32'd1), 1'b0, r});
    dir_rows.push_back('{mk(4'd15, 4'hf, 4'hf, 4'hf, 4'hf, 32'hffffffff), 1'b0, r});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_instr(dir_rows[i].ins);
      // typed expectations replace the predicted ones, so a wrong predictor shows
      if (dir_rows[i].known) pending_results[$] = dir_rows[i].res;
    end

    // three idling phases over the random programme
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 20 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) send_instr(rand_instr());
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
